// ===== rtl/swm_pkg.sv =====
package swm_pkg;

  // Widths fixed by the sample and configuration fields
  localparam int unsigned DATA_W = 32;
  localparam int unsigned CFG_W  = 7;

  // Per-cell status seen by both neighbours
  typedef struct packed {
    logic valid;  // cell holds a window entry
    logic gt;     // entry is greater than the incoming sample
    logic rem;    // entry is the oldest and leaves the window
    logic above;  // the leaving entry sits below this cell
  } swm_status_t;

endpackage

// ===== rtl/sliding_window_median_core.sv =====
// Sliding-window median filter over signed 32-bit samples. The window is a
// row of MAX_WINDOW cells kept in ascending order; each cell also carries the
// age of its entry, so the oldest one is found and dropped in the same cycle
// that the new sample is compared against every cell and slotted in. One
// sample is taken per clock cycle unless a result waits on median_ready_i;
// the rate is set by the compare-and-shift across the cell row, whose
// longest path is the carry that marks the cells above the leaving entry.
// The lower median (rank ceil(k/2)) is read straight from the cell row and
// held while the result waits. Writing window_size (0 reads as 1, values
// above MAX_WINDOW saturate) restarts the window: the next window_size-1
// samples give no result. No clearing pass is needed after reset.
module sliding_window_median_core #(
  parameter int unsigned MAX_WINDOW = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [swm_pkg::CFG_W-1:0]         window_size_i,
  input  logic                              sample_valid_i,
  output logic                              sample_ready_o,
  input  logic signed [swm_pkg::DATA_W-1:0] sample_i,
  output logic                              median_valid_o,
  input  logic                              median_ready_i,
  output logic signed [swm_pkg::DATA_W-1:0] median_o
);
  import swm_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);

  logic [FW-1:0] win_q, win_d, fill_q, fill_d, cfg_win;
  logic [AW-1:0] mid_q, mid_d, age_last;
  logic          out_valid_q, out_valid_d;
  logic          in_fire, full;

  swm_status_t              st     [MAX_WINDOW];
  logic                     rem_bl [MAX_WINDOW+1];
  logic signed [DATA_W-1:0] val    [MAX_WINDOW];
  logic [AW-1:0]            age    [MAX_WINDOW];

  assign cfg_ready_o    = 1'b1;
  assign sample_ready_o = !out_valid_q || median_ready_i;
  assign in_fire        = sample_valid_i && sample_ready_o;
  assign full           = fill_q == win_q;
  assign age_last       = AW'(win_q - 1'b1);

  // Clamp the written window size to 1..MAX_WINDOW
  always_comb begin
    priority if (window_size_i == '0) begin
      cfg_win = FW'(1);
    end else if (32'(window_size_i) > 32'(MAX_WINDOW)) begin
      cfg_win = FW'(MAX_WINDOW);
    end else begin
      cfg_win = FW'(window_size_i);
    end
  end

  // Window, fill and result control
  always_comb begin
    win_d       = win_q;
    mid_d       = mid_q;
    fill_d      = fill_q;
    out_valid_d = out_valid_q;
    priority if (cfg_valid_i) begin
      win_d       = cfg_win;
      mid_d       = AW'((cfg_win - 1'b1) >> 1);
      fill_d      = '0;
      out_valid_d = 1'b0;
    end else if (in_fire) begin
      fill_d      = full ? fill_q : fill_q + 1'b1;
      out_valid_d = (fill_q + 1'b1) >= win_q;
    end else if (median_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= FW'(1);
      mid_q       <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      win_q       <= win_d;
      mid_q       <= mid_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Row of sorted cells; the leaving-entry mark ripples upward
  assign rem_bl[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    swm_status_t              dn_st, up_st;
    logic signed [DATA_W-1:0] dn_val, up_val;
    logic [AW-1:0]            dn_age, up_age;

    if (i == 0) begin : g_lo
      assign dn_st  = '0;
      assign dn_val = '0;
      assign dn_age = '0;
    end else begin : g_mid_lo
      assign dn_st  = st[i-1];
      assign dn_val = val[i-1];
      assign dn_age = age[i-1];
    end

    if (i == MAX_WINDOW - 1) begin : g_hi
      assign up_st  = '0;
      assign up_val = '0;
      assign up_age = '0;
    end else begin : g_mid_hi
      assign up_st  = st[i+1];
      assign up_val = val[i+1];
      assign up_age = age[i+1];
    end

    swm_cell #(
      .IDX (i),
      .AW  (AW),
      .FW  (FW)
    ) u_cell (
      .clk_i       (clk_i),
      .en_i        (in_fire),
      .sample_i    (sample_i),
      .full_i      (full),
      .fill_i      (fill_q),
      .age_last_i  (age_last),
      .rem_below_i (rem_bl[i]),
      .dn_st_i     (dn_st),
      .dn_val_i    (dn_val),
      .dn_age_i    (dn_age),
      .up_st_i     (up_st),
      .up_val_i    (up_val),
      .up_age_i    (up_age),
      .st_o        (st[i]),
      .rem_below_o (rem_bl[i+1]),
      .val_o       (val[i]),
      .age_o       (age[i])
    );
  end

  // Read the lower median from its fixed rank in the row
  assign median_valid_o = out_valid_q;
  assign median_o       = val[mid_q];

endmodule

// ===== rtl/swm_cell.sv =====
module swm_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 1,
  parameter int unsigned FW  = 1
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [swm_pkg::DATA_W-1:0] sample_i,
  input  logic                       full_i,
  input  logic [FW-1:0]              fill_i,
  input  logic [AW-1:0]              age_last_i,
  input  logic                       rem_below_i,
  input  swm_pkg::swm_status_t       dn_st_i,
  input  logic signed [swm_pkg::DATA_W-1:0] dn_val_i,
  input  logic [AW-1:0]              dn_age_i,
  input  swm_pkg::swm_status_t       up_st_i,
  input  logic signed [swm_pkg::DATA_W-1:0] up_val_i,
  input  logic [AW-1:0]              up_age_i,
  output swm_pkg::swm_status_t       st_o,
  output logic                       rem_below_o,
  output logic signed [swm_pkg::DATA_W-1:0] val_o,
  output logic [AW-1:0]              age_o
);
  import swm_pkg::*;

  logic signed [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]            age_q, age_d;
  swm_status_t              st;
  logic                     keep_own, from_up, from_dn;

  // Classify own entry against the incoming item and the leaving entry
  always_comb begin
    st.valid = FW'(IDX) < fill_i;
    st.gt    = st.valid && (val_q > sample_i);
    st.rem   = st.valid && full_i && (age_q == age_last_i);
    st.above = rem_below_i;
  end

  assign st_o        = st;
  assign rem_below_o = rem_below_i | st.rem;
  assign val_o       = val_q;
  assign age_o       = age_q;

  // Pick the entry that lands here: own, from above, from below, or the item
  assign keep_own = st.valid && !st.rem && (st.above == st.gt);
  assign from_up  = up_st_i.valid && up_st_i.above && !up_st_i.gt;
  assign from_dn  = dn_st_i.valid && !dn_st_i.above && !dn_st_i.rem && dn_st_i.gt;

  always_comb begin
    priority if (keep_own) begin
      val_d = val_q;
      age_d = age_q + 1'b1;
    end else if (from_up) begin
      val_d = up_val_i;
      age_d = up_age_i + 1'b1;
    end else if (from_dn) begin
      val_d = dn_val_i;
      age_d = dn_age_i + 1'b1;
    end else begin
      val_d = sample_i;
      age_d = '0;
    end
  end

  // Advance on every accepted item
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      val_q <= val_d;
      age_q <= age_d;
    end
  end

endmodule
